/* sv/mbrtu_pkg.sv */
package mbrtu_pkg;

  localparam int unsigned REG_COUNT = 2;
  localparam int unsigned IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int unsigned FRAME_MAX = 3 + 2 * REG_COUNT;
  localparam int unsigned K_W = $clog2(FRAME_MAX + 1);
  localparam int unsigned FRAME_SHORT = 5;
  localparam int unsigned REQ_BYTES = 6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0] NODE_ADDR_RESET = 8'd1;
  localparam logic [7:0] SHORT_LEN_BYTE = 8'd7;

  localparam logic [7:0] FUNC_READ = 8'h03;
  localparam logic [7:0] FUNC_WRITE = 8'h06;
  localparam logic [7:0] FUNC_SET_ADDR = 8'h69;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_CALC   = 7'b0001000,
    S_EMIT   = 7'b0010000,
    S_CRC_LO = 7'b0100000,
    S_CRC_HI = 7'b1000000
  } state_e;

  function automatic logic [15:0] reg_reset_value(input int unsigned idx);
    logic [15:0] val;
    if (idx == 0) begin
      val = 16'd69;
    end else if (idx == 1) begin
      val = 16'd96;
    end else begin
      val = 16'd0;
    end
    return val;
  endfunction

endpackage

/* sv/modbus_rtu_slave_responder.sv */
// Modbus RTU slave responder. Each input beat is one decoded request; the block checks the
// node address and the CRC-16 of the request, carries out a read (0x03), register write (0x06)
// or node address change (0x69), and returns the response frame one byte per output beat,
// CRC low byte first, with resp_last_o on the final CRC byte. Dropped requests give no beats.
// All CRC work runs through one bit-serial CRC unit, one bit per cycle, and the block takes
// one request at a time: after accept the unit checks the six request bytes, a decision step
// follows, then each response byte is folded into the CRC and then sent as one output beat,
// followed by the two CRC beats. A write or address change response has 5 bytes, a read of n
// registers 3 + 2n bytes, and a dropped request ends after the decision step.
module modbus_rtu_slave_responder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  dest_addr_i,
  input  logic [7:0]  func_code_i,
  input  logic [15:0] reg_addr_i,
  input  logic [15:0] payload_i,
  input  logic [15:0] crc_rx_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  resp_byte_o,
  output logic        resp_last_o
);

  mbrtu_pkg::state_e state_q, state_d;

  logic [7:0]  dest_q;
  logic [7:0]  func_q;
  logic [15:0] ra_q;
  logic [15:0] pl_q;
  logic [15:0] crc_rx_q;

  logic [15:0] regs_q [mbrtu_pkg::REG_COUNT];
  logic [7:0]  node_q;

  logic [15:0] crc_q;
  logic [2:0]  bit_q;
  logic [mbrtu_pkg::K_W-1:0] k_q;
  logic [mbrtu_pkg::K_W-1:0] last_k_q;
  logic [mbrtu_pkg::IDX_W-1:0] ptr_q;
  logic        hi_q;
  logic        is_read_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;

  logic        in_accept;
  logic        out_accept;
  logic [7:0]  req_byte;
  logic [7:0]  frame_byte;
  logic [7:0]  crc_src;
  logic        fb;
  logic [15:0] crc_next;
  logic        hdr_ok;
  logic        read_ok;
  logic        write_ok;
  logic        set_ok;
  logic        resp_ok;
  logic [15:0] reg_val;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != mbrtu_pkg::S_IDLE);
  assign out_valid_o = (state_q == mbrtu_pkg::S_EMIT) || (state_q == mbrtu_pkg::S_CRC_LO) ||
                       (state_q == mbrtu_pkg::S_CRC_HI);
  assign resp_byte_o = out_byte_q;
  assign resp_last_o = out_last_q;

  always_comb begin
    case (k_q)
      mbrtu_pkg::K_W'(0): req_byte = dest_q;
      mbrtu_pkg::K_W'(1): req_byte = func_q;
      mbrtu_pkg::K_W'(2): req_byte = ra_q[15:8];
      mbrtu_pkg::K_W'(3): req_byte = ra_q[7:0];
      mbrtu_pkg::K_W'(4): req_byte = pl_q[15:8];
      default:            req_byte = pl_q[7:0];
    endcase
  end

  assign reg_val = regs_q[ptr_q];

  always_comb begin
    case (k_q)
      mbrtu_pkg::K_W'(0): frame_byte = node_q;
      mbrtu_pkg::K_W'(1): frame_byte = func_q;
      mbrtu_pkg::K_W'(2): begin
        frame_byte = is_read_q ? 8'({1'b0, pl_q, 1'b0} + 18'd5) : mbrtu_pkg::SHORT_LEN_BYTE;
      end
      default: begin
        if (is_read_q) begin
          frame_byte = hi_q ? reg_val[15:8] : reg_val[7:0];
        end else begin
          frame_byte = hi_q ? pl_q[15:8] : pl_q[7:0];
        end
      end
    endcase
  end

  // The shared CRC unit folds in one data bit per cycle, least significant bit first.
  assign crc_src = (state_q == mbrtu_pkg::S_CHECK) ? req_byte : frame_byte;
  assign fb = crc_q[0] ^ crc_src[bit_q];
  assign crc_next = {1'b0, crc_q[15:1]} ^ (fb ? mbrtu_pkg::CRC_POLY : 16'h0000);

  assign hdr_ok = (dest_q == node_q) && (crc_q == crc_rx_q);
  assign read_ok = (func_q == mbrtu_pkg::FUNC_READ) &&
                   (ra_q < 16'(mbrtu_pkg::REG_COUNT)) && (pl_q != 16'd0) &&
                   (pl_q <= 16'(mbrtu_pkg::REG_COUNT));
  assign write_ok = (func_q == mbrtu_pkg::FUNC_WRITE) && (ra_q < 16'(mbrtu_pkg::REG_COUNT));
  assign set_ok = (func_q == mbrtu_pkg::FUNC_SET_ADDR) && (pl_q[15:8] == 8'd0);
  assign resp_ok = hdr_ok && (read_ok || write_ok || set_ok);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbrtu_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = mbrtu_pkg::S_CHECK;
        end
      end
      mbrtu_pkg::S_CHECK: begin
        if ((bit_q == 3'd7) && (k_q == mbrtu_pkg::K_W'(mbrtu_pkg::REQ_BYTES - 1))) begin
          state_d = mbrtu_pkg::S_DECIDE;
        end
      end
      mbrtu_pkg::S_DECIDE: begin
        state_d = resp_ok ? mbrtu_pkg::S_CALC : mbrtu_pkg::S_IDLE;
      end
      mbrtu_pkg::S_CALC: begin
        if (bit_q == 3'd7) begin
          state_d = mbrtu_pkg::S_EMIT;
        end
      end
      mbrtu_pkg::S_EMIT: begin
        if (out_accept) begin
          state_d = (k_q == last_k_q) ? mbrtu_pkg::S_CRC_LO : mbrtu_pkg::S_CALC;
        end
      end
      mbrtu_pkg::S_CRC_LO: begin
        if (out_accept) begin
          state_d = mbrtu_pkg::S_CRC_HI;
        end
      end
      mbrtu_pkg::S_CRC_HI: begin
        if (out_accept) begin
          state_d = mbrtu_pkg::S_IDLE;
        end
      end
      default: state_d = mbrtu_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbrtu_pkg::S_IDLE;
      node_q <= mbrtu_pkg::NODE_ADDR_RESET;
      for (int i = 0; i < mbrtu_pkg::REG_COUNT; i++) begin
        regs_q[i] <= mbrtu_pkg::reg_reset_value(i);
      end
      crc_q <= mbrtu_pkg::CRC_INIT;
      bit_q <= '0;
      k_q <= '0;
      last_k_q <= '0;
      ptr_q <= '0;
      hi_q <= 1'b1;
      is_read_q <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        mbrtu_pkg::S_IDLE: begin
          crc_q <= mbrtu_pkg::CRC_INIT;
          bit_q <= '0;
          k_q <= '0;
        end
        mbrtu_pkg::S_CHECK: begin
          crc_q <= crc_next;
          bit_q <= bit_q + 3'd1;
          if (bit_q == 3'd7) begin
            k_q <= k_q + mbrtu_pkg::K_W'(1);
          end
        end
        mbrtu_pkg::S_DECIDE: begin
          crc_q <= mbrtu_pkg::CRC_INIT;
          bit_q <= '0;
          k_q <= '0;
          hi_q <= 1'b1;
          out_last_q <= 1'b0;
          is_read_q <= read_ok;
          ptr_q <= mbrtu_pkg::IDX_W'(pl_q - 16'd1);
          last_k_q <= read_ok ? mbrtu_pkg::K_W'({1'b0, pl_q, 1'b0} + 18'd2)
                              : mbrtu_pkg::K_W'(mbrtu_pkg::FRAME_SHORT - 1);
          if (hdr_ok && write_ok) begin
            regs_q[ra_q[mbrtu_pkg::IDX_W-1:0]] <= pl_q;
          end
          if (hdr_ok && set_ok) begin
            node_q <= pl_q[7:0];
          end
        end
        mbrtu_pkg::S_CALC: begin
          crc_q <= crc_next;
          bit_q <= bit_q + 3'd1;
        end
        mbrtu_pkg::S_EMIT: begin
          if (out_accept) begin
            k_q <= k_q + mbrtu_pkg::K_W'(1);
            if (k_q >= mbrtu_pkg::K_W'(3)) begin
              hi_q <= !hi_q;
              if (!hi_q) begin
                ptr_q <= ptr_q - mbrtu_pkg::IDX_W'(1);
              end
            end
          end
        end
        mbrtu_pkg::S_CRC_LO: begin
          if (out_accept) begin
            out_last_q <= 1'b1;
          end
        end
        mbrtu_pkg::S_CRC_HI: begin
          if (out_accept) begin
            out_last_q <= 1'b0;
          end
        end
        default: begin
          out_last_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      dest_q <= dest_addr_i;
      func_q <= func_code_i;
      ra_q <= reg_addr_i;
      pl_q <= payload_i;
      crc_rx_q <= crc_rx_i;
    end
    if ((state_q == mbrtu_pkg::S_CALC) && (bit_q == 3'd7)) begin
      out_byte_q <= frame_byte;
    end else if ((state_q == mbrtu_pkg::S_EMIT) && out_accept && (k_q == last_k_q)) begin
      out_byte_q <= crc_q[7:0];
    end else if ((state_q == mbrtu_pkg::S_CRC_LO) && out_accept) begin
      out_byte_q <= crc_q[15:8];
    end
  end

endmodule

/* dv/modbus_rtu_slave_responder_test.sv */
module modbus_rtu_slave_responder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 106;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } resp_beat_t;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] v);
    logic [15:0] acc;
    acc = c ^ {8'h00, v};
    for (int b = 0; b < 8; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ mbrtu_pkg::CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] request_crc(input logic [7:0] a, input logic [7:0] f,
                                              input logic [15:0] r, input logic [15:0] p);
    logic [15:0] c;
    c = mbrtu_pkg::CRC_INIT;
    c = crc_step(c, a);
    c = crc_step(c, f);
    c = crc_step(c, r[15:8]);
    c = crc_step(c, r[7:0]);
    c = crc_step(c, p[15:8]);
    c = crc_step(c, p[7:0]);
    return c;
  endfunction

  class resp_scoreboard;
    logic [15:0] regs [mbrtu_pkg::REG_COUNT];
    logic [7:0]  node_addr;
    logic [15:0] frame_crc;
    resp_beat_t  resp_q [$];
    int reads, writes, addr_sets, dropped, requests, beats_seen, mismatches;

    function new();
      for (int i = 0; i < mbrtu_pkg::REG_COUNT; i++) begin
        regs[i] = 16'd0;
      end
      regs[0] = 16'd69;
      if (mbrtu_pkg::REG_COUNT > 1) begin
        regs[1] = 16'd96;
      end
      node_addr = mbrtu_pkg::NODE_ADDR_RESET;
    endfunction

    function void push_byte(logic [7:0] b);
      resp_beat_t beat;
      beat.data = b;
      beat.last = 1'b0;
      frame_crc = crc_step(frame_crc, b);
      resp_q.push_back(beat);
    endfunction

    function void push_crc();
      resp_beat_t beat;
      beat.data = frame_crc[7:0];
      beat.last = 1'b0;
      resp_q.push_back(beat);
      beat.data = frame_crc[15:8];
      beat.last = 1'b1;
      resp_q.push_back(beat);
    endfunction

    function void note_request(logic [7:0] a, logic [7:0] f, logic [15:0] r,
                               logic [15:0] p, logic [15:0] c);
      int n;
      requests++;
      frame_crc = mbrtu_pkg::CRC_INIT;
      if (a != node_addr || request_crc(a, f, r, p) != c) begin
        dropped++;
        return;
      end
      case (f)
        mbrtu_pkg::FUNC_READ: begin
          if (r < mbrtu_pkg::REG_COUNT && p >= 16'd1 && p <= mbrtu_pkg::REG_COUNT) begin
            n = int'(p);
            push_byte(node_addr);
            push_byte(mbrtu_pkg::FUNC_READ);
            push_byte(8'(2 * n + 5));
            for (int i = n; i > 0; i--) begin
              push_byte(regs[i - 1][15:8]);
              push_byte(regs[i - 1][7:0]);
            end
            push_crc();
            reads++;
          end else begin
            dropped++;
          end
        end
        mbrtu_pkg::FUNC_WRITE: begin
          if (r < mbrtu_pkg::REG_COUNT) begin
            regs[r] = p;
            push_byte(node_addr);
            push_byte(mbrtu_pkg::FUNC_WRITE);
            push_byte(mbrtu_pkg::SHORT_LEN_BYTE);
            push_byte(p[15:8]);
            push_byte(p[7:0]);
            push_crc();
            writes++;
          end else begin
            dropped++;
          end
        end
        mbrtu_pkg::FUNC_SET_ADDR: begin
          if (p <= 16'd255) begin
            node_addr = p[7:0];
            push_byte(node_addr);
            push_byte(mbrtu_pkg::FUNC_SET_ADDR);
            push_byte(mbrtu_pkg::SHORT_LEN_BYTE);
            push_byte(8'h00);
            push_byte(p[7:0]);
            push_crc();
            addr_sets++;
          end else begin
            dropped++;
          end
        end
        default: begin
          dropped++;
        end
      endcase
    endfunction

    function void check_beat(logic [7:0] data, logic last);
      resp_beat_t want;
      beats_seen++;
      if (resp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected response beat: byte %02h last %0b", data, last);
        end
        return;
      end
      want = resp_q.pop_front();
      if (data !== want.data || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Response beat %0d: expected byte %02h last %0b, got byte %02h last %0b",
                   beats_seen, want.data, want.last, data, last);
        end
      end
    endfunction

    function int pending();
      return resp_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  dest_addr_i = 8'd0;
  logic [7:0]  func_code_i = 8'd0;
  logic [15:0] reg_addr_i = 16'd0;
  logic [15:0] payload_i = 16'd0;
  logic [15:0] crc_rx_i = 16'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  resp_byte_o;
  logic        resp_last_o;

  resp_scoreboard sb;
  int idle_pct = 19;
  int cycle_count = 0;

  modbus_rtu_slave_responder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .dest_addr_i (dest_addr_i),
    .func_code_i (func_code_i),
    .reg_addr_i  (reg_addr_i),
    .payload_i   (payload_i),
    .crc_rx_i    (crc_rx_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .resp_byte_o (resp_byte_o),
    .resp_last_o (resp_last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run exceeded %0d cycles with %0d beats outstanding.", CYCLE_LIMIT,
               sb.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_beat(resp_byte_o, resp_last_o);
    end
    out_stall_i <= ($urandom_range(99) < idle_pct);
  end

  task automatic send_request(input logic [7:0] a, input logic [7:0] f, input logic [15:0] r,
                              input logic [15:0] p, input logic [15:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    dest_addr_i <= a;
    func_code_i <= f;
    reg_addr_i  <= r;
    payload_i   <= p;
    crc_rx_i    <= c;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    sb.note_request(a, f, r, p, c);
  endtask

  task automatic send_good(input logic [7:0] f, input logic [15:0] r, input logic [15:0] p);
    send_request(sb.node_addr, f, r, p, request_crc(sb.node_addr, f, r, p));
  endtask

  initial begin
    logic [7:0]  a;
    logic [7:0]  f;
    logic [15:0] r;
    logic [15:0] p;
    logic [15:0] c;
    int roll;
    int kind;

    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_good(mbrtu_pkg::FUNC_READ, 16'd0, 16'd1);
    send_good(mbrtu_pkg::FUNC_READ, 16'd1, 16'(mbrtu_pkg::REG_COUNT));
    send_good(mbrtu_pkg::FUNC_READ, 16'd0, 16'd0);
    send_good(mbrtu_pkg::FUNC_READ, 16'd0, 16'(mbrtu_pkg::REG_COUNT + 1));
    send_good(mbrtu_pkg::FUNC_READ, 16'd0, 16'hFFFF);
    send_good(mbrtu_pkg::FUNC_READ, 16'(mbrtu_pkg::REG_COUNT), 16'd1);
    send_good(mbrtu_pkg::FUNC_READ, 16'hFFFF, 16'd1);
    send_good(mbrtu_pkg::FUNC_WRITE, 16'd0, 16'hFFFF);
    send_good(mbrtu_pkg::FUNC_WRITE, 16'(mbrtu_pkg::REG_COUNT - 1), 16'h0000);
    send_good(mbrtu_pkg::FUNC_READ, 16'd0, 16'(mbrtu_pkg::REG_COUNT));
    send_good(mbrtu_pkg::FUNC_WRITE, 16'(mbrtu_pkg::REG_COUNT), 16'h1234);
    send_good(mbrtu_pkg::FUNC_WRITE, 16'hFFFF, 16'h5678);
    send_good(mbrtu_pkg::FUNC_SET_ADDR, 16'd0, 16'd256);
    send_good(mbrtu_pkg::FUNC_SET_ADDR, 16'd0, 16'hFFFF);
    send_good(mbrtu_pkg::FUNC_SET_ADDR, 16'hFFFF, 16'd255);
    send_good(mbrtu_pkg::FUNC_READ, 16'd0, 16'(mbrtu_pkg::REG_COUNT));
    send_request(8'd1, mbrtu_pkg::FUNC_READ, 16'd0, 16'd1,
                 request_crc(8'd1, mbrtu_pkg::FUNC_READ, 16'd0, 16'd1));
    c = request_crc(sb.node_addr, mbrtu_pkg::FUNC_READ, 16'd0, 16'd1);
    send_request(sb.node_addr, mbrtu_pkg::FUNC_READ, 16'd0, 16'd1, c ^ 16'h0001);
    send_good(8'h00, 16'd0, 16'd1);
    send_good(8'hFF, 16'd0, 16'd1);
    send_good(mbrtu_pkg::FUNC_SET_ADDR, 16'd0, 16'd0);
    send_good(mbrtu_pkg::FUNC_WRITE, 16'(mbrtu_pkg::REG_COUNT - 1), 16'h8000);
    send_good(mbrtu_pkg::FUNC_SET_ADDR, 16'd0, 16'd1);
    send_good(mbrtu_pkg::FUNC_READ, 16'd0, 16'd1);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      idle_pct = (k >= 50 && k < 85) ? 0 : 19;
      roll = $urandom_range(99);
      if (roll < 72) begin
        kind = $urandom_range(9);
        if (kind < 4) begin
          r = ($urandom_range(9) == 0) ? 16'($urandom)
                                       : 16'($urandom_range(mbrtu_pkg::REG_COUNT - 1));
          p = ($urandom_range(9) == 0) ? 16'($urandom)
                                       : 16'($urandom_range(mbrtu_pkg::REG_COUNT, 1));
          send_good(mbrtu_pkg::FUNC_READ, r, p);
        end else if (kind < 8) begin
          r = ($urandom_range(9) == 0) ? 16'($urandom)
                                       : 16'($urandom_range(mbrtu_pkg::REG_COUNT - 1));
          send_good(mbrtu_pkg::FUNC_WRITE, r, 16'($urandom));
        end else begin
          p = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(255));
          send_good(mbrtu_pkg::FUNC_SET_ADDR, 16'($urandom), p);
        end
      end else begin
        kind = $urandom_range(3);
        a = sb.node_addr;
        f = 8'($urandom);
        r = 16'($urandom);
        p = 16'($urandom);
        case (kind)
          0: begin
            f = mbrtu_pkg::FUNC_WRITE;
            r = 16'($urandom_range(mbrtu_pkg::REG_COUNT - 1));
            c = request_crc(a, f, r, p) ^ 16'($urandom_range(65535, 1));
          end
          1: begin
            a = sb.node_addr ^ 8'($urandom_range(255, 1));
            f = mbrtu_pkg::FUNC_READ;
            r = 16'd0;
            p = 16'd1;
            c = request_crc(a, f, r, p);
          end
          2: begin
            a = 8'($urandom);
            c = 16'($urandom);
          end
          default: begin
            while (f == mbrtu_pkg::FUNC_READ || f == mbrtu_pkg::FUNC_WRITE ||
                   f == mbrtu_pkg::FUNC_SET_ADDR) begin
              f = 8'($urandom);
            end
            c = request_crc(a, f, r, p);
          end
        endcase
        send_request(a, f, r, p, c);
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests: %0d reads, %0d writes, %0d address changes, %0d dropped.",
             sb.requests, sb.reads, sb.writes, sb.addr_sets, sb.dropped);
    $display("Checked %0d response beats, %0d of them wrong, %0d still outstanding.",
             sb.beats_seen, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/mbrtu_pkg.sv
sv/modbus_rtu_slave_responder.sv
dv/modbus_rtu_slave_responder_test.sv
